FILE: sv/i2c_master_register_read_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef I2C_MASTER_REGISTER_READ_UNIT_MACROS_SVH
`define I2C_MASTER_REGISTER_READ_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define I2CMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define I2CMR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/i2cmr_pkg.sv
package i2cmr_pkg;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
  localparam logic [7:0]  READ_FLAG         = 8'h01;
  localparam logic [3:0]  BYTE_BITS         = 4'd8;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } result_t;

endpackage

FILE: sv/i2cmr_core.sv
module i2cmr_core
  import i2cmr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  input  logic          accept,
  input  logic          command,
  input  logic [7:0]    dev_addr,
  input  logic [7:0]    reg_addr,
  input  logic          sda_in,
  output result_t       result
);

  typedef enum logic [4:0] {
    PH_IDLE         = 5'd0,
    PH_ST_HIGH      = 5'd1,
    PH_ST_HOLD      = 5'd2,
    PH_DEV_LOW      = 5'd3,
    PH_DEV_HIGH     = 5'd4,
    PH_DEV_ACK_LOW  = 5'd5,
    PH_DEV_ACK_HIGH = 5'd6,
    PH_REG_LOW      = 5'd7,
    PH_REG_HIGH     = 5'd8,
    PH_REG_ACK_LOW  = 5'd9,
    PH_REG_ACK_HIGH = 5'd10,
    PH_RS_LOW       = 5'd11,
    PH_RS_HIGH      = 5'd12,
    PH_RS_HOLD      = 5'd13,
    PH_RDA_LOW      = 5'd14,
    PH_RDA_HIGH     = 5'd15,
    PH_RDA_ACK_LOW  = 5'd16,
    PH_RDA_ACK_HIGH = 5'd17,
    PH_RX_LOW       = 5'd18,
    PH_RX_HIGH      = 5'd19,
    PH_AK_LOW       = 5'd20,
    PH_AK_HIGH      = 5'd21,
    PH_SP_LOW       = 5'd22,
    PH_SP_HIGH      = 5'd23
  } phase_t;

  logic [15:0] half_period;
  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] tick_divider, tick_divider_next;
  logic [7:0]  latched_device, latched_device_next;
  logic [7:0]  latched_register, latched_register_next;
  logic [7:0]  received_byte, received_byte_next;
  logic        done;
  logic [15:0] hp;
  logic        tick_end;

  assign hp       = (half_period == 16'd0) ? 16'd1 : half_period;
  assign tick_end = ({1'b0, tick_divider} + 17'd1) >= {1'b0, hp};

  always_comb begin
    phase_next            = phase;
    bit_count_next        = bit_count;
    shift_byte_next       = shift_byte;
    tick_divider_next     = tick_divider;
    latched_device_next   = latched_device;
    latched_register_next = latched_register;
    received_byte_next    = received_byte;
    done                  = 1'b0;
    if (phase == PH_IDLE) begin
      if (command) begin
        latched_device_next   = dev_addr;
        latched_register_next = reg_addr;
        tick_divider_next     = 16'd0;
        bit_count_next        = 4'd0;
        shift_byte_next       = 8'd0;
        phase_next            = PH_ST_HIGH;
      end
    end else if (tick_end) begin
      tick_divider_next = 16'd0;
      unique case (phase)
        PH_DEV_LOW, PH_REG_LOW, PH_RDA_LOW,
        PH_DEV_ACK_LOW, PH_REG_ACK_LOW, PH_RDA_ACK_LOW,
        PH_ST_HIGH, PH_RS_LOW, PH_RS_HIGH, PH_RX_LOW,
        PH_AK_LOW, PH_AK_HIGH, PH_SP_LOW: begin
          phase_next = phase_t'(phase + 5'd1);
        end
        PH_DEV_HIGH, PH_REG_HIGH, PH_RDA_HIGH: begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_count_next  = bit_count + 4'd1;
          phase_next      = (bit_count_next >= BYTE_BITS) ? phase_t'(phase + 5'd1)
                                                          : phase_t'(phase - 5'd1);
        end
        PH_ST_HOLD: begin
          shift_byte_next = latched_device;
          bit_count_next  = 4'd0;
          phase_next      = PH_DEV_LOW;
        end
        PH_DEV_ACK_HIGH: begin
          shift_byte_next = latched_register;
          bit_count_next  = 4'd0;
          phase_next      = PH_REG_LOW;
        end
        PH_REG_ACK_HIGH: begin
          phase_next = PH_RS_LOW;
        end
        PH_RS_HOLD: begin
          shift_byte_next = latched_device | READ_FLAG;
          bit_count_next  = 4'd0;
          phase_next      = PH_RDA_LOW;
        end
        PH_RDA_ACK_HIGH: begin
          shift_byte_next = 8'd0;
          bit_count_next  = 4'd0;
          phase_next      = PH_RX_LOW;
        end
        PH_RX_HIGH: begin
          shift_byte_next = {shift_byte[6:0], sda_in};
          bit_count_next  = bit_count + 4'd1;
          if (bit_count_next >= BYTE_BITS) begin
            received_byte_next = shift_byte_next;
            phase_next         = PH_AK_LOW;
          end else begin
            phase_next = PH_RX_LOW;
          end
        end
        PH_SP_HIGH: begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end else begin
      tick_divider_next = tick_divider + 16'd1;
    end
  end

  always_comb begin
    result.busy_res  = (phase_next != PH_IDLE);
    result.done_res  = done;
    result.read_data = received_byte_next;
    unique case (phase_next)
      PH_DEV_LOW, PH_REG_LOW, PH_RDA_LOW: begin
        result.scl_level = 1'b0;
        result.sda_level = shift_byte_next[7];
      end
      PH_DEV_HIGH, PH_REG_HIGH, PH_RDA_HIGH: begin
        result.scl_level = 1'b1;
        result.sda_level = shift_byte_next[7];
      end
      PH_DEV_ACK_LOW, PH_REG_ACK_LOW, PH_RDA_ACK_LOW, PH_RS_LOW, PH_RX_LOW: begin
        result.scl_level = 1'b0;
        result.sda_level = 1'b1;
      end
      PH_ST_HOLD, PH_RS_HOLD, PH_AK_HIGH, PH_SP_HIGH: begin
        result.scl_level = 1'b1;
        result.sda_level = 1'b0;
      end
      PH_AK_LOW, PH_SP_LOW: begin
        result.scl_level = 1'b0;
        result.sda_level = 1'b0;
      end
      default: begin
        result.scl_level = 1'b1;
        result.sda_level = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period      <= HALF_PERIOD_RESET;
      phase            <= PH_IDLE;
      bit_count        <= 4'd0;
      shift_byte       <= 8'd0;
      tick_divider     <= 16'd0;
      latched_device   <= 8'd0;
      latched_register <= 8'd0;
      received_byte    <= 8'd0;
    end else begin
      if (cfg_we) begin
        half_period <= cfg_data;
      end
      if (accept) begin
        phase            <= phase_next;
        bit_count        <= bit_count_next;
        shift_byte       <= shift_byte_next;
        tick_divider     <= tick_divider_next;
        latched_device   <= latched_device_next;
        latched_register <= latched_register_next;
        received_byte    <= received_byte_next;
      end
    end
  end

endmodule

FILE: sv/i2cmr_obuf.sv
module i2cmr_obuf
  import i2cmr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  output logic    space,
  output logic    valid,
  input  logic    taken,
  output result_t result_out
);

  assign space = !valid || taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (load) begin
        valid <= 1'b1;
      end else if (taken) begin
        valid <= 1'b0;
      end
    end
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

FILE: sv/i2c_master_register_read_unit.sv
// Each accepted input beat's result is registered and offered as its result beat in the next cycle.
// Throughput: one tick beat per cycle; the result register drains while the
// next beat is accepted, so only a stalled result register holds off input.
// Reset (rst, synchronous): sequencer idle, half period 50 ticks, latched
// bytes and received byte zero, result register empty.
module i2c_master_register_read_unit
  import i2cmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  dev_addr,
  input  logic [7:0]  reg_addr,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_level,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data
);

  result_t result_next;
  result_t result_reg;
  logic    accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  i2cmr_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .command        (command),
    .dev_addr       (dev_addr),
    .reg_addr       (reg_addr),
    .sda_in         (sda_in),
    .result         (result_next)
  );

  i2cmr_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .result_in  (result_next),
    .space      (in_ready),
    .valid      (out_valid),
    .taken      (out_ready),
    .result_out (result_reg)
  );

  assign scl_level = result_reg.scl_level;
  assign sda_level = result_reg.sda_level;
  assign busy_res  = result_reg.busy_res;
  assign done_res  = result_reg.done_res;
  assign read_data = result_reg.read_data;

endmodule

FILE: sv/i2cmr_checker.sv
`include "i2c_master_register_read_unit_macros.svh"

module i2cmr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_level,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_data
);

  `I2CMR_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid, "result beat present after reset")
  `I2CMR_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(read_data), "stalled result beat changed")
  `I2CMR_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty result register")
  `I2CMR_ASSERT(a_done_is_stop, out_valid && done_res |-> !busy_res && scl_level && sda_level, "done beat is not a released bus")
  `I2CMR_ASSERT(a_idle_released, out_valid && !busy_res |-> scl_level && sda_level, "idle beat drives a line low")

endmodule

bind i2c_master_register_read_unit i2cmr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .scl_level (scl_level),
  .sda_level (sda_level),
  .busy_res  (busy_res),
  .done_res  (done_res),
  .read_data (read_data)
);

FILE: tb/i2c_master_register_read_unit_checker.sv
`timescale 1ns / 100ps

module i2c_master_register_read_unit_checker
  import i2cmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [7:0]  dev_addr,
  input  logic [7:0]  reg_addr,
  input  logic        sda_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        scl_level,
  input  logic        sda_level,
  input  logic        busy_res,
  input  logic        done_res,
  input  logic [7:0]  read_data,
  output int          fail_count,
  output int          pending,
  output int          reads_done
);

  typedef enum logic [4:0] {
    SEQ_IDLE,
    SEQ_START_HIGH,
    SEQ_START_HOLD,
    SEQ_BIT_LOW,
    SEQ_BIT_HIGH,
    SEQ_SACK_LOW,
    SEQ_SACK_HIGH,
    SEQ_RS_LOW,
    SEQ_RS_HIGH,
    SEQ_RS_HOLD,
    SEQ_RX_LOW,
    SEQ_RX_HIGH,
    SEQ_MACK_LOW,
    SEQ_MACK_HIGH,
    SEQ_STOP_LOW,
    SEQ_STOP_HIGH
  } seq_e;

  typedef enum logic [1:0] {
    BYTE_DEVICE,
    BYTE_REGISTER,
    BYTE_READ_ADDR
  } tx_byte_e;

  localparam int REPORT_LIMIT = 10;

  logic [15:0] half_period;
  seq_e        seq;
  tx_byte_e    tx_byte;
  logic [3:0]  bit_count;
  logic [7:0]  shifter;
  logic [15:0] divider;
  logic [7:0]  lat_device;
  logic [7:0]  lat_register;
  logic [7:0]  rx_byte;
  result_t     expected_ticks[$];
  int          fails = 0;
  int          reads = 0;

  function automatic void load_byte(input tx_byte_e which, input logic [7:0] value);
    tx_byte = which;
    shifter = value;
    bit_count = '0;
    seq = SEQ_BIT_LOW;
  endfunction

  function automatic logic end_half_period(input logic sda);
    logic done;
    done = 1'b0;
    case (seq)
      SEQ_START_HIGH: seq = SEQ_START_HOLD;
      SEQ_START_HOLD: load_byte(BYTE_DEVICE, lat_device);
      SEQ_BIT_LOW: seq = SEQ_BIT_HIGH;
      SEQ_BIT_HIGH: begin
        shifter = shifter << 1;
        bit_count = bit_count + 4'd1;
        seq = (bit_count >= BYTE_BITS) ? SEQ_SACK_LOW : SEQ_BIT_LOW;
      end
      SEQ_SACK_LOW: seq = SEQ_SACK_HIGH;
      SEQ_SACK_HIGH: begin
        case (tx_byte)
          BYTE_DEVICE: load_byte(BYTE_REGISTER, lat_register);
          BYTE_REGISTER: seq = SEQ_RS_LOW;
          default: begin
            shifter = '0;
            bit_count = '0;
            seq = SEQ_RX_LOW;
          end
        endcase
      end
      SEQ_RS_LOW: seq = SEQ_RS_HIGH;
      SEQ_RS_HIGH: seq = SEQ_RS_HOLD;
      SEQ_RS_HOLD: load_byte(BYTE_READ_ADDR, lat_device | READ_FLAG);
      SEQ_RX_LOW: seq = SEQ_RX_HIGH;
      SEQ_RX_HIGH: begin
        shifter = {shifter[6:0], sda};
        bit_count = bit_count + 4'd1;
        if (bit_count >= BYTE_BITS) begin
          rx_byte = shifter;
          seq = SEQ_MACK_LOW;
        end else begin
          seq = SEQ_RX_LOW;
        end
      end
      SEQ_MACK_LOW: seq = SEQ_MACK_HIGH;
      SEQ_MACK_HIGH: seq = SEQ_STOP_LOW;
      SEQ_STOP_LOW: seq = SEQ_STOP_HIGH;
      SEQ_STOP_HIGH: begin
        seq = SEQ_IDLE;
        done = 1'b1;
      end
      default: seq = SEQ_IDLE;
    endcase
    return done;
  endfunction

  function automatic result_t predict_tick(input logic cmd, input logic [7:0] dev,
                                           input logic [7:0] regb, input logic sda);
    logic [15:0] period;
    result_t     r;
    period = (half_period == '0) ? 16'd1 : half_period;
    r.done_res = 1'b0;
    if (seq == SEQ_IDLE) begin
      if (cmd) begin
        lat_device = dev;
        lat_register = regb;
        divider = '0;
        bit_count = '0;
        shifter = '0;
        seq = SEQ_START_HIGH;
      end
    end else if ({1'b0, divider} + 17'd1 >= {1'b0, period}) begin
      divider = '0;
      r.done_res = end_half_period(sda);
    end else begin
      divider = divider + 16'd1;
    end
    case (seq)
      SEQ_BIT_LOW: begin
        r.scl_level = 1'b0;
        r.sda_level = shifter[7];
      end
      SEQ_BIT_HIGH: begin
        r.scl_level = 1'b1;
        r.sda_level = shifter[7];
      end
      SEQ_SACK_LOW, SEQ_RS_LOW, SEQ_RX_LOW: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b1;
      end
      SEQ_START_HOLD, SEQ_RS_HOLD, SEQ_MACK_HIGH, SEQ_STOP_HIGH: begin
        r.scl_level = 1'b1;
        r.sda_level = 1'b0;
      end
      SEQ_MACK_LOW, SEQ_STOP_LOW: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
      end
      default: begin
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
      end
    endcase
    r.busy_res = (seq != SEQ_IDLE);
    r.read_data = rx_byte;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      half_period = HALF_PERIOD_RESET;
      seq = SEQ_IDLE;
      tx_byte = BYTE_DEVICE;
      bit_count = '0;
      shifter = '0;
      divider = '0;
      lat_device = '0;
      lat_register = '0;
      rx_byte = '0;
      expected_ticks.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {scl_level, sda_level, busy_res, done_res, read_data};
        if (expected_ticks.size() == 0) begin
          if (fails < REPORT_LIMIT) begin
            $display("%0t: result beat with nothing expected: scl %b sda %b busy %b done %b data %02h",
                     $time, got.scl_level, got.sda_level, got.busy_res, got.done_res,
                     got.read_data);
          end
          fails++;
        end else begin
          want = expected_ticks.pop_front();
          if (got !== want) begin
            if (fails < REPORT_LIMIT) begin
              $display("%0t: expected scl %b sda %b busy %b done %b data %02h", $time,
                       want.scl_level, want.sda_level, want.busy_res, want.done_res,
                       want.read_data);
              $display("%0t:      got scl %b sda %b busy %b done %b data %02h", $time,
                       got.scl_level, got.sda_level, got.busy_res, got.done_res,
                       got.read_data);
            end
            fails++;
          end
          if (want.done_res) begin
            reads++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        half_period = cfg_data;
      end
      if (in_valid && in_ready) begin
        expected_ticks.push_back(predict_tick(command, dev_addr, reg_addr, sda_in));
      end
    end
    pending <= expected_ticks.size();
    fail_count <= fails;
    reads_done <= reads;
  end

endmodule

FILE: tb/tb_i2c_master_register_read_unit.sv
`timescale 1ns / 100ps

module tb_i2c_master_register_read_unit;

  localparam int          RESET_CYCLES    = 9;
  localparam int          DEFAULT_TICKS   = 60;
  localparam int          RANDOM_PHASES   = 3;
  localparam int          TICKS_PER_PHASE = 24;
  localparam int          LONG_HOLD       = 80;
  localparam int          SLOW_TICKS      = 40;
  localparam int          SDA_LOW         = 0;
  localparam int          SDA_HIGH        = 1;
  localparam int          SDA_RANDOM      = 2;
  localparam logic [15:0] PERIOD_ZERO     = 16'h0000;
  localparam logic [15:0] PERIOD_ONE      = 16'h0001;
  localparam logic [15:0] PERIOD_MAX      = 16'hFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic [7:0]  dev_addr = '0;
  logic [7:0]  reg_addr = '0;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl_level;
  logic        sda_level;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_data;

  int   fail_count;
  int   pending;
  int   reads_done;
  int   result_beats = 0;
  logic last_busy = 1'b0;
  int   ticks_sent = 0;
  int   settings_used = 1;
  int   send_burst = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  i2c_master_register_read_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .dev_addr(dev_addr),
    .reg_addr(reg_addr),
    .sda_in(sda_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .scl_level(scl_level),
    .sda_level(sda_level),
    .busy_res(busy_res),
    .done_res(done_res),
    .read_data(read_data)
  );

  i2c_master_register_read_unit_checker read_checker (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .dev_addr(dev_addr),
    .reg_addr(reg_addr),
    .sda_in(sda_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .scl_level(scl_level),
    .sda_level(sda_level),
    .busy_res(busy_res),
    .done_res(done_res),
    .read_data(read_data),
    .fail_count(fail_count),
    .pending(pending),
    .reads_done(reads_done)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      result_beats <= result_beats + 1;
      last_busy <= busy_res;
    end
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    if (roll < 4) begin
      send_burst = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 8'h00;
    if (roll < 30) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_tick(input logic cmd, input logic [7:0] dev, input logic [7:0] regb,
                           input logic sda);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    dev_addr <= dev;
    reg_addr <= regb;
    sda_in <= sda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic random_tick(input logic allow_cmd, input int sda_mode);
    logic cmd;
    logic sda;
    cmd = allow_cmd && ($urandom_range(0, 11) == 0);
    sda = (sda_mode == SDA_RANDOM) ? 1'($urandom_range(0, 1)) : (sda_mode == SDA_HIGH);
    send_tick(cmd, pick_byte(), pick_byte(), sda);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Plain ticks are sent until the last result beat shows the sequencer idle.
  task automatic finish_read(input int sda_mode);
    logic active;
    active = 1'b1;
    while (active) begin
      settle();
      if (last_busy) begin
        repeat (16) random_tick(1'b0, sda_mode);
      end else begin
        active = 1'b0;
      end
    end
  endtask

  task automatic write_period(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : receiver
    int holds_done;
    int hold_mark;
    holds_done = 0;
    while (rst) @(posedge clk);
    forever begin
      hold_mark = (holds_done == 0) ? 250 : 500;
      if (holds_done < 2 && result_beats >= hold_mark) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_stall()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int p;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_tick(1'b0, 8'hFF, 8'hFF, 1'b1);
    send_tick(1'b0, 8'h00, 8'h00, 1'b0);
    send_tick(1'b1, 8'hFF, 8'h00, 1'b1);
    send_tick(1'b1, 8'h00, 8'hFF, 1'b0);
    // The read at the reset half period runs past its first half period, then speeds up.
    repeat (DEFAULT_TICKS) random_tick(1'b0, SDA_RANDOM);
    settle();

    write_period(PERIOD_ONE);
    finish_read(SDA_RANDOM);
    send_tick(1'b1, 8'h00, 8'hFF, 1'b0);
    finish_read(SDA_HIGH);
    send_tick(1'b1, 8'hA5, 8'h5A, 1'b1);
    finish_read(SDA_LOW);

    write_period(PERIOD_ZERO);
    send_tick(1'b1, 8'h3C, 8'hC3, 1'b0);
    finish_read(SDA_RANDOM);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_period(16'($urandom_range(0, 2)));
      repeat (TICKS_PER_PHASE) random_tick(1'b1, SDA_RANDOM);
      finish_read(SDA_RANDOM);
    end

    // The longest half period is only started; a full read would take millions of ticks.
    write_period(PERIOD_MAX);
    send_tick(1'b1, pick_byte(), pick_byte(), 1'b1);
    repeat (SLOW_TICKS) random_tick(1'b0, SDA_RANDOM);
    settle();

    $display("Sent %0d tick beats under %0d half-period settings, from zero to the maximum.",
             ticks_sent, settings_used);
    $display("%0d register reads ran through to STOP; %0d result beats were checked.",
             reads_done, result_beats);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
